/* rtl/core/huffman_code_bit_packer_defines.svh */
// Assertion macros for the Huffman code bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define HCBP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbp same-cycle check failed");
// Check that a condition implies another in the cycle after it.
`define HCBP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbp next-cycle check failed");
`else
`define HCBP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HCBP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/hcbp_pkg.sv */
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int CMD_W            = 2;
  localparam int SYM_W            = 8;
  localparam int LEN_IN_W         = 6;
  localparam int CODE_W           = 32;
  localparam int BYTE_W           = 8;
  localparam int BYTE_SH          = 3;
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int TABLE_DEPTH      = 256;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

endpackage

/* rtl/core/hcbp_code_table.sv */
// Code table memory: one entry per symbol holding code length and code bits.
module hcbp_code_table import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int LEN_W        = $clog2(DEF_MAX_CODE_LEN + 1)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [SYM_W-1:0]    wr_addr,
  input  logic [LEN_IN_W-1:0] wr_len,
  input  logic [CODE_W-1:0]   wr_bits,
  input  logic                rd_en,
  input  logic [SYM_W-1:0]    rd_addr,
  output logic [LEN_W-1:0]    rd_len,
  output logic [CODE_W-1:0]   rd_bits
);

  localparam int ENTRY_W = LEN_W + CODE_W;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [LEN_W-1:0]   len_sat;

  // Saturate long code lengths to the configured maximum.
  always_comb begin
    if (wr_len > LEN_IN_W'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = LEN_W'(wr_len);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {len_sat, wr_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_len  = rd_q[ENTRY_W-1 -: LEN_W];
  assign rd_bits = rd_q[CODE_W-1:0];

endmodule

/* rtl/core/huffman_code_bit_packer.sv */
// An accepted encode or flush enters the packing stage and then the output serializer.
// Throughput: one transaction per cycle while each yields at most one byte and out_ready is
// high; a longer encode holds the packing stage until the output port takes its last byte.
// Reset clears the pending bits, the packing stage and the output serializer.
// The code table memory is not cleared; an entry must be loaded before it is encoded.
`include "huffman_code_bit_packer_defines.svh"
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SYM_W-1:0]    symbol,
  input  logic [LEN_IN_W-1:0] code_len,
  input  logic [CODE_W-1:0]   code_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                padded,
  output logic                last
);

  // Stored code length width, bytes per encode, and the packing window.
  localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
  localparam int MAX_RES   = (BYTE_W - 1 + MAX_CODE_LEN) / BYTE_W;
  localparam int ACC_BYTES = (2 * BYTE_W - 2 + MAX_CODE_LEN) / BYTE_W;
  localparam int ACC_W     = ACC_BYTES * BYTE_W;
  localparam int SUM_W     = $clog2(ACC_W + 1);
  localparam int NB_W      = SUM_W - BYTE_SH;
  localparam int CNT_W     = $clog2(MAX_RES + 1);
  localparam int WIDE_W    = ACC_W + CODE_W;

  // Handshake and table access.
  logic               in_fire;
  logic               out_fire;
  logic               tbl_wr;
  logic               tbl_rd;
  logic [LEN_W-1:0]   rd_len;
  logic [CODE_W-1:0]  rd_bits;

  // Packing stage: holds one encode or flush while the table data arrives.
  logic               s1_valid;
  cmd_t               s1_cmd;
  logic               s1_fire;
  logic               ser_free;

  // Pending partial byte, bits gathered from bit 7 down.
  logic [BYTE_W-1:0]  pend_byte;
  logic [BYTE_SH-1:0] pend_cnt;

  // Output serializer: bytes left-justified, one leaves per output handshake.
  logic [ACC_W-1:0]   ser_buf;
  logic [CNT_W-1:0]   ser_cnt;
  logic               ser_pad;

  // Packing datapath.
  logic [WIDE_W-1:0]  code_mask;
  logic [WIDE_W-1:0]  code_w;
  logic [WIDE_W-1:0]  code_sh;
  logic [SUM_W-1:0]   bit_sum;
  logic [SUM_W-1:0]   shamt;
  logic [ACC_W-1:0]   pend_acc;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_rest;
  logic [NB_W-1:0]    nb;
  logic [BYTE_SH-1:0] rest_cnt;
  logic [BYTE_W-1:0]  rest_byte;

  // The packing stage may move on only once the serializer drains this cycle.
  assign ser_free = (ser_cnt == '0) || ((ser_cnt == CNT_W'(1)) && out_ready);
  assign s1_fire  = s1_valid && ser_free;
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Loads write the table at accept; encodes read it at accept so the data
  // lands with the item in the packing stage. A load followed by an encode of
  // the same symbol sees the new entry since the write lands at an earlier edge.
  assign tbl_wr = in_fire && (cmd == CMD_LOAD);
  assign tbl_rd = in_fire && (cmd == CMD_ENCODE);

  hcbp_code_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .LEN_W       (LEN_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (tbl_wr),
    .wr_addr(symbol),
    .wr_len (code_len),
    .wr_bits(code_bits),
    .rd_en  (tbl_rd),
    .rd_addr(symbol),
    .rd_len (rd_len),
    .rd_bits(rd_bits)
  );

  // Advance the packing stage; loads and unknown commands do not enter it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid && ((cmd == CMD_ENCODE) || (cmd == CMD_FLUSH));
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd <= cmd_t'(cmd);
    end
  end

  // Append the masked code right after the pending bits in one window, then
  // split the window into whole bytes and the new partial byte.
  always_comb begin
    code_mask = (WIDE_W'(1) << rd_len) - WIDE_W'(1);
    code_w    = WIDE_W'(rd_bits) & code_mask;
    bit_sum   = SUM_W'(pend_cnt) + SUM_W'(rd_len);
    shamt     = SUM_W'(ACC_W) - bit_sum;
    code_sh   = code_w << shamt;
    pend_acc  = ACC_W'(pend_byte) << (ACC_W - BYTE_W);
    acc       = pend_acc | code_sh[ACC_W-1:0];
    nb        = bit_sum[SUM_W-1:BYTE_SH];
    rest_cnt  = bit_sum[BYTE_SH-1:0];
    acc_rest  = acc << {nb, {BYTE_SH{1'b0}}};
    rest_byte = acc_rest[ACC_W-1 -: BYTE_W];
  end

  // Pending bits: keep the partial byte after an encode, drop it on a flush.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_byte <= '0;
      pend_cnt  <= '0;
    end else if (s1_fire) begin
      case (s1_cmd)
        CMD_ENCODE: begin
          pend_byte <= rest_byte;
          pend_cnt  <= rest_cnt;
        end
        CMD_FLUSH: begin
          pend_byte <= '0;
          pend_cnt  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Serializer: load whole bytes, or a flush's padded partial byte, from the packing stage, else shift one out.
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_cnt <= '0;
      ser_pad <= 1'b0;
    end else if (s1_fire) begin
      case (s1_cmd)
        CMD_ENCODE: begin
          ser_cnt <= CNT_W'(nb);
          ser_pad <= 1'b0;
        end
        CMD_FLUSH: begin
          ser_cnt <= (pend_cnt != '0) ? CNT_W'(1) : '0;
          ser_pad <= 1'b1;
        end
        default: begin
          ser_cnt <= '0;
        end
      endcase
    end else if (out_fire) begin
      ser_cnt <= ser_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      case (s1_cmd)
        CMD_ENCODE: ser_buf <= acc;
        CMD_FLUSH:  ser_buf <= pend_acc;
        default:    ser_buf <= ser_buf;
      endcase
    end else if (out_fire) begin
      ser_buf <= ser_buf << BYTE_W;
    end
  end

  assign out_valid = (ser_cnt != '0);
  assign out_byte  = ser_buf[ACC_W-1 -: BYTE_W];
  assign last      = (ser_cnt == CNT_W'(1));
  assign padded    = ser_pad;

  // A busy packing stage only lets a new transaction in when it moves on.
  `HCBP_ASSERT_IMP(a_stage_adv, clk, rst, s1_valid && in_ready, s1_fire)
  // The serializer never holds more bytes than one encode can make.
  `HCBP_ASSERT_IMP(a_ser_bound, clk, rst, 1'b1, ser_cnt <= CNT_W'(MAX_RES))
  // A padded byte is always the only and last byte of its flush.
  `HCBP_ASSERT_IMP(a_pad_last, clk, rst, out_valid && padded, last)
  // A flush leaves nothing pending.
  `HCBP_ASSERT_NXT(a_flush_clr, clk, rst, s1_fire && (s1_cmd == CMD_FLUSH),
                   (pend_cnt == '0) && (pend_byte == '0))

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the Huffman code bit packer: random bursts, stalls, byte checks.
module tb_top;
  import hcbp_pkg::*;

  // The block ignores the fourth command code entirely.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PACK_MAX_LEN = DEF_MAX_CODE_LEN;
  localparam int RANDOM_ITEMS = 240;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // One queued request for the driver; drain_mark makes the sender hold off
  // until every predicted byte has come out.
  typedef struct {
    logic [CMD_W-1:0]    op;
    logic [SYM_W-1:0]    sym;
    logic [LEN_IN_W-1:0] len;
    logic [CODE_W-1:0]   bits;
    bit                  drain_mark;
  } pack_req_t;

  // One packed output byte as the block should present it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pad;
    logic              fin;
  } packed_byte_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = CMD_LOAD;
  logic [SYM_W-1:0]    symbol = '0;
  logic [LEN_IN_W-1:0] code_len = '0;
  logic [CODE_W-1:0]   code_bits = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                padded;
  logic                last;

  pack_req_t    req_q[$];
  packed_byte_t byte_q[$];

  // Stimulus-side bookkeeping: which table entries have been loaded so far.
  bit              loaded_map[TABLE_DEPTH];
  logic [SYM_W-1:0] loaded_syms[$];

  // Predictor state: the code table and the partial byte being gathered.
  logic [LEN_IN_W-1:0] len_tbl[TABLE_DEPTH];
  logic [CODE_W-1:0]   code_tbl[TABLE_DEPTH];
  logic [BYTE_W-1:0]   acc_byte;
  int                  acc_cnt;

  int n_loads, n_encodes, n_flushes, n_ignored;
  int n_bytes, n_padded_bytes, n_mismatch;

  // Sender burst/gap counters and receiver stall pattern state.
  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  huffman_code_bit_packer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .symbol    (symbol),
    .code_len  (code_len),
    .code_bits (code_bits),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .padded    (padded),
    .last      (last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Queue a request; remember loaded entries so encodes never hit an
  // unwritten table slot.
  task automatic queue_req(input logic [CMD_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [LEN_IN_W-1:0] len, input logic [CODE_W-1:0] bits);
    pack_req_t r;
    r = '{op: op, sym: sym, len: len, bits: bits, drain_mark: 1'b0};
    req_q.push_back(r);
    if (op == CMD_LOAD && !loaded_map[sym]) begin
      loaded_map[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Mostly short codes, with zero length, full length and over-long lengths
  // mixed in.
  function automatic logic [LEN_IN_W-1:0] pick_code_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return LEN_IN_W'($urandom_range(1, 8));
    if (p < 80) return LEN_IN_W'($urandom_range(9, 20));
    if (p < 88) return LEN_IN_W'($urandom_range(21, PACK_MAX_LEN));
    if (p < 93) return '0;
    return LEN_IN_W'($urandom_range(PACK_MAX_LEN + 1, 63));
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: update the table or append code bits MSB first, emitting
  // each full byte; a flush emits the zero-padded partial byte.
  // ---------------------------------------------------------------------
  task automatic pack_transaction(input logic [CMD_W-1:0] op, input logic [SYM_W-1:0] sym,
                                  input logic [LEN_IN_W-1:0] len,
                                  input logic [CODE_W-1:0] bits);
    int pos;
    int first;
    packed_byte_t tail;
    case (op)
      CMD_LOAD: begin
        n_loads++;
        // Saturate over-long lengths; bits above the length stay stored but unused.
        len_tbl[sym] = (len > PACK_MAX_LEN) ? LEN_IN_W'(PACK_MAX_LEN) : len;
        code_tbl[sym] = bits;
      end
      CMD_ENCODE: begin
        n_encodes++;
        first = byte_q.size();
        for (pos = int'(len_tbl[sym]) - 1; pos >= 0; pos--) begin
          acc_byte[7 - acc_cnt] = (pos < CODE_W) ? code_tbl[sym][pos] : 1'b0;
          acc_cnt++;
          if (acc_cnt == BYTE_W) begin
            byte_q.push_back('{data: acc_byte, pad: 1'b0, fin: 1'b0});
            acc_byte = '0;
            acc_cnt = 0;
          end
        end
        // Mark the final byte of this encode.
        if (byte_q.size() > first) begin
          tail = byte_q.pop_back();
          tail.fin = 1'b1;
          byte_q.push_back(tail);
        end
      end
      CMD_FLUSH: begin
        n_flushes++;
        if (acc_cnt != 0)
          byte_q.push_back('{data: acc_byte, pad: 1'b1, fin: 1'b1});
        acc_byte = '0;
        acc_cnt = 0;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= REPORT_LIMIT)
      $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------
  // Driver: present queued requests in bursts with random gaps; hold the
  // payload until the transaction is accepted.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pack_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() > 0 && req_q[0].drain_mark) begin
        // Hold off until nothing is in flight and every byte has arrived.
        if (!in_valid && byte_q.size() == 0)
          void'(req_q.pop_front());
        in_valid <= 1'b0;
      end else if (req_q.size() > 0) begin
        req = req_q.pop_front();
        in_valid  <= 1'b1;
        cmd       <= req.op;
        symbol    <= req.sym;
        code_len  <= req.len;
        code_bits <= req.bits;
        if (burst_left <= 1) begin
          // Long bursts now and then give stretches with no idling.
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: switch at random between always ready, coin-flip stalls,
  // one-in-four ready and heavy stalls.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 80);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= (rx_tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each accepted byte against the oldest prediction, then
  // predict the bytes of each accepted input transaction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    packed_byte_t seen;
    packed_byte_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = '{data: out_byte, pad: padded, fin: last};
        n_bytes++;
        if (padded === 1'b1)
          n_padded_bytes++;
        if (byte_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h padded %0b last %0b",
                                  seen.data, seen.pad, seen.fin));
        end else begin
          want = byte_q.pop_front();
          if (seen.data !== want.data || seen.pad !== want.pad || seen.fin !== want.fin)
            flag_mismatch($sformatf(
              "byte %0d expected %02h padded %0b last %0b, got %02h padded %0b last %0b",
              n_bytes, want.data, want.pad, want.fin, seen.data, seen.pad, seen.fin));
        end
      end
      if (in_valid && in_ready)
        pack_transaction(cmd, symbol, code_len, code_bits);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------
  initial begin
    int i;
    int p;
    pack_req_t drain_req;
    acc_byte = '0;
    acc_cnt = 0;
    drain_req = '{op: CMD_LOAD, sym: '0, len: '0, bits: '0, drain_mark: 1'b1};

    // Directed part: extreme lengths and codes, every command, the corner cases.
    queue_req(CMD_FLUSH,  8'd0,   6'd0,  32'h0000_0000); // flush with nothing pending
    queue_req(CMD_LOAD,   8'd0,   6'd0,  32'hFFFF_FFFF); // zero-length code
    queue_req(CMD_LOAD,   8'd255, 6'd32, 32'hFFFF_FFFF); // full-length code
    queue_req(CMD_LOAD,   8'd1,   6'd63, 32'hA5A5_5A5A); // over-long, saturates
    queue_req(CMD_LOAD,   8'd2,   6'd3,  32'hFFFF_FFF5); // upper bits ignored
    queue_req(CMD_LOAD,   8'd3,   6'd1,  32'h0000_0001);
    queue_req(CMD_LOAD,   8'd128, 6'd8,  32'h0000_00C3);
    queue_req(CMD_ENCODE, 8'd0,   6'd0,  32'h0000_0000); // emits nothing
    queue_req(CMD_ENCODE, 8'd255, 6'd0,  32'h0000_0000); // four bytes at once
    queue_req(CMD_ENCODE, 8'd2,   6'd0,  32'h0000_0000); // leave three bits pending
    queue_req(CMD_LOAD,   8'd5,   6'd7,  32'h0000_0055); // load must keep pending bits
    queue_req(CMD_ENCODE, 8'd1,   6'd0,  32'h0000_0000); // unaligned 32-bit code
    queue_req(CMD_UNUSED, 8'hFF,  6'h3F, 32'hFFFF_FFFF); // ignored command
    queue_req(CMD_ENCODE, 8'd3,   6'd0,  32'h0000_0000);
    queue_req(CMD_FLUSH,  8'd0,   6'd0,  32'h0000_0000); // padded partial byte
    queue_req(CMD_FLUSH,  8'd0,   6'd0,  32'h0000_0000); // nothing left to flush
    queue_req(CMD_ENCODE, 8'd128, 6'd0,  32'h0000_0000); // exactly one byte
    queue_req(CMD_ENCODE, 8'd5,   6'd0,  32'h0000_0000);
    queue_req(CMD_ENCODE, 8'd3,   6'd0,  32'h0000_0000); // completes a byte
    queue_req(CMD_LOAD,   8'd255, 6'd32, 32'h0000_0000); // overwrite, all zeros
    queue_req(CMD_ENCODE, 8'd255, 6'd0,  32'h0000_0000);
    queue_req(CMD_ENCODE, 8'd2,   6'd0,  32'h0000_0000);
    queue_req(CMD_FLUSH,  8'd0,   6'd0,  32'h0000_0000);
    req_q.push_back(drain_req);

    // Seed the table with random entries before the random stream.
    for (i = 0; i < 16; i++)
      queue_req(CMD_LOAD, SYM_W'($urandom_range(0, 255)), pick_code_len(), $urandom);

    // Random part: mostly encodes of loaded symbols, with reloads and
    // flushes; pause twice until the output has drained.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3 || i == 2 * RANDOM_ITEMS / 3)
        req_q.push_back(drain_req);
      p = $urandom_range(0, 99);
      if (p < 14)
        queue_req(CMD_LOAD, SYM_W'($urandom_range(0, 255)), pick_code_len(), $urandom);
      else if (p < 86)
        queue_req(CMD_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                  LEN_IN_W'($urandom), $urandom);
      else
        queue_req(CMD_FLUSH, SYM_W'($urandom), LEN_IN_W'($urandom), $urandom);
      if ($urandom_range(0, 39) == 0)
        queue_req(CMD_UNUSED, SYM_W'($urandom), LEN_IN_W'($urandom), $urandom);
    end
    queue_req(CMD_FLUSH, 8'd0, 6'd0, 32'h0000_0000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the sender to empty its queue and every byte to arrive;
    // sample on the falling edge so all rising-edge updates have settled.
    @(negedge clk);
    while (req_q.size() > 0 || in_valid || byte_q.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (byte_q.size() > 0)
      flag_mismatch($sformatf("%0d predicted bytes never arrived", byte_q.size()));

    $display("Covered %0d loads, %0d encodes, %0d flushes, %0d ignored commands.",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("Checked %0d output bytes (%0d zero-padded), %0d mismatches.",
             n_bytes, n_padded_bytes, n_mismatch);
    if (n_mismatch == 0) begin
      $display("[huffman_code_bit_packer] OK");
    end else begin
      $display("[huffman_code_bit_packer] ERROR");
    end
    $finish;
  end

  // Watchdog: end the run if the handshakes stop making progress.
  initial begin
    #4000000;
    $display("Timeout with %0d requests and %0d bytes outstanding.",
             req_q.size(), byte_q.size());
    $display("[huffman_code_bit_packer] ERROR");
    $finish;
  end

endmodule
